// ----- rtl/core/wpm_pkg.sv -----
// wpm_pkg: shared types and constants for the wildcard pattern matcher
// no dependencies; used by the channel interfaces, the cell and the core
`default_nettype none

package wpm_pkg;

    localparam int WPM_MAX_PATTERN = 64;
    localparam int LIMIT_W         = 11;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1999;

    localparam logic [7:0] CH_ONE  = 8'h3F;  // '?'
    localparam logic [7:0] CH_STAR = 8'h2A;  // '*'

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_TEXT   = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TEXT     = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_t;

    // broadcast from the core to every cell
    typedef struct packed {
        logic       clear;
        logic       append;
        logic       restart;
        logic       step;
        logic [7:0] ch;
    } wpm_cmd_t;

    // handed from one cell to its right neighbor
    typedef struct packed {
        logic act;
        logic star;
        logic adv;
        logic tail;
        logic wrote;
    } wpm_link_t;

endpackage

`default_nettype wire

// ----- rtl/core/wpm_in_if.sv -----
// wpm_in_if: valid/ready channel carrying input items (kind, character)
// depends on wpm_pkg
`default_nettype none

interface wpm_in_if
    import wpm_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] character;

    modport source (output valid, output kind, output character, input ready);
    modport sink   (input valid, input kind, input character, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wpm_out_if.sv -----
// wpm_out_if: valid/ready channel carrying verdicts (matched, error_code)
// depends on wpm_pkg
`default_nettype none

interface wpm_out_if
    import wpm_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       matched;
    logic [1:0] error_code;

    modport source (output valid, output matched, output error_code, input ready);
    modport sink   (input valid, input matched, input error_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wildcard_pattern_matcher_core.sv -----
// wildcard_pattern_matcher_core: whole-string '?' / '*' matcher, a row of
// MAX_PATTERN+1 cells updated in parallel on every text beat.
// throughput: one input beat per cycle when not stalled; the verdict of
// an end beat is registered and offered in the cycle after it is taken.
// a full output register stalls input only while the verdict is not taken.
// reset: pattern empty, limit 1999, text restarted; no clearing pass.
`default_nettype none

module wildcard_pattern_matcher_core
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = WPM_MAX_PATTERN
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_wdata,
    wpm_in_if.sink                  req,
    wpm_out_if.source               rsp
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int NCELLS = MAX_PATTERN + 1;
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_PATTERN);

    logic [LIMIT_W-1:0] limit_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic [LIMIT_W-1:0] count_reg;
    logic [LIMIT_W-1:0] count_next;
    logic               long_reg;
    logic               long_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               matched_reg;
    logic               matched_next;
    err_t               err_reg;
    err_t               err_next;

    logic        take;
    logic        is_clear;
    logic        is_append;
    logic        is_text;
    logic        is_end;
    logic        text_bad;
    wpm_cmd_t    cmd;
    wpm_link_t   link [NCELLS+1];
    logic [NCELLS-1:0] hit_vec;
    logic [NCELLS-1:0] tail_vec;
    logic [NCELLS-1:0] act_vec;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;
    assign is_clear  = take && (req.kind == KIND_CLEAR);
    assign is_append = take && (req.kind == KIND_APPEND);
    assign is_text   = take && (req.kind == KIND_TEXT);
    assign is_end    = take && (req.kind == KIND_END);

    always_comb
    begin
        cmd.clear   = is_clear;
        cmd.append  = is_append && (len_reg != LEN_FULL);
        cmd.restart = is_clear || is_append || is_end;
        cmd.step    = is_text;
        cmd.ch      = req.character;
    end

    assign link[0] = '0;

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        wpm_cell #(
            .FIRST (i == 0)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (link[i]),
            .right (link[i+1]),
            .hit   (hit_vec[i])
        );
        assign tail_vec[i] = link[i+1].tail;
        assign act_vec[i]  = link[i+1].act;
    end

    assign text_bad = (count_reg == '0) || long_reg || (count_reg > limit_reg);

    always_comb
    begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        count_next     = count_reg;
        long_next      = long_reg;
        matched_next   = matched_reg;
        err_next       = err_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;

        if (is_clear)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        else if (is_append)
        begin
            // length counts every append, also stars folded into a run
            if (len_reg == LEN_FULL)
                ovf_next = 1'b1;
            else
                len_next = len_reg + 1'b1;
        end

        if (is_text)
        begin
            if (count_reg >= limit_reg)
                long_next = 1'b1;
            else
                count_next = count_reg + 1'b1;
        end
        else if (take)
        begin
            count_next = '0;
            long_next  = 1'b0;
        end

        if (is_end)
        begin
            rsp_valid_next = 1'b1;
            if (text_bad)
            begin
                err_next     = ERR_TEXT;
                matched_next = 1'b0;
            end
            else if (ovf_reg)
            begin
                err_next     = ERR_OVERFLOW;
                matched_next = 1'b0;
            end
            else
            begin
                err_next     = ERR_NONE;
                matched_next = |hit_vec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            count_reg     <= '0;
            long_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            count_reg     <= count_next;
            long_reg      <= long_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        err_reg     <= err_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.matched    = matched_reg;
    assign rsp.error_code = err_reg;

    // exactly one cell marks the end of the stored pattern
    a_tail_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(tail_vec))
        else $error("tail mark not one-hot");

    // any pattern beat or end beat restarts the text at position zero
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (req.kind != KIND_TEXT)) |=> (act_vec == NCELLS'(1)))
        else $error("text not restarted");

    a_match_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.matched) |-> (rsp.error_code == ERR_NONE))
        else $error("match reported with error");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_FULL)
        else $error("pattern length past limit");

endmodule

`default_nettype wire

// ----- rtl/core/wpm_cell.sv -----
// wpm_cell: one pattern position (uses wpm_pkg); holds the pattern byte, the
// active flag and tail mark; but for the core, talks only to its two neighbors
`default_nettype none

module wpm_cell
    import wpm_pkg::*;
#(
    parameter bit FIRST = 1'b0
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire wpm_cmd_t  cmd,
    input  wire wpm_link_t left,
    output wpm_link_t      right,
    output logic           hit
);

    logic [7:0] char_reg;
    logic       used_reg;
    logic       act_reg;
    logic       act_next;
    logic       tail_reg;
    logic       tail_next;
    logic       used_next;

    logic star;
    logic closed;
    logic adv;
    logic dup;
    logic wrote;

    assign star   = used_reg && (char_reg == CH_STAR);
    // a run of stars is stored as one star, so closure is a single hop
    assign closed = act_reg || (left.act && left.star);
    assign adv    = closed && used_reg &&
                    (star || (char_reg == CH_ONE) || (char_reg == cmd.ch));
    assign dup    = (cmd.ch == CH_STAR) && left.star;
    assign wrote  = cmd.append && tail_reg && !dup;
    assign hit    = tail_reg && closed;

    always_comb
    begin
        right.act   = act_reg;
        right.star  = star;
        right.adv   = adv;
        right.tail  = tail_reg;
        right.wrote = wrote;
    end

    always_comb
    begin
        used_next = used_reg;
        tail_next = tail_reg;
        act_next  = act_reg;
        if (cmd.clear)
        begin
            used_next = 1'b0;
            tail_next = FIRST;
        end
        else if (cmd.append)
        begin
            used_next = used_reg || wrote;
            tail_next = (tail_reg && !wrote) || left.wrote;
        end
        if (cmd.restart)
            act_next = FIRST;
        else if (cmd.step)
            act_next = (closed && star) || left.adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tail_reg <= FIRST;
            act_reg  <= FIRST;
        end
        else
        begin
            used_reg <= used_next;
            tail_reg <= tail_next;
            act_reg  <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wrote)
            char_reg <= cmd.ch;
    end

endmodule

`default_nettype wire
